/* design/lsm_pkg.sv */
`default_nettype none

package lsm_pkg;

    // fixed sizes of the register file and the result word
    localparam int PAT_BYTES       = 32;
    localparam int PATTERN_MAX_DEF = 32;
    localparam int LINE_MAX_DEF    = 2048;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int PLEN_W          = 6;
    localparam int LEN_OUT_W       = 11;
    localparam int CNT_W           = 32;
    localparam int OUT_TDATA_W     = 80;

    // character codes
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PAT_LO     = 3'd0,
        REG_PAT_MID_LO = 3'd1,
        REG_PAT_MID_HI = 3'd2,
        REG_PAT_HI     = 3'd3,
        REG_PAT_LEN    = 3'd4,
        REG_FOLD_CASE  = 3'd5,
        REG_INVERT     = 3'd6
    } cfg_reg_t;

    // current configuration, byte 0 of the pattern in the lowest bits
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [PLEN_W-1:0]         plen;
        logic                      fold;
        logic                      invert;
    } cfg_t;

    // window control from the line tracker to the matcher
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] data;
    } match_ctrl_t;

    // ascii upper to lower case when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c >= CHAR_UP_A) && (c <= CHAR_UP_Z))
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/line_substring_matcher.sv */
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata[7:0] data_byte, tlast end_of_input
// m_axis    out  m_axis_tvalid/tready   tdata: see port, tlast final_report,
//                                       tuser line_present
// cfg       in   cfg_wr_en              cfg_index, cfg_wdata
//
// one word per cycle while results are taken; each word waits in the input
// register while the window compare and line update run, then its result
// (if any) sits in the output register until taken.
// reset sets the line number to one and clears the selected count, the line state and both valid flags.
// a stalled result holds the stage; the input register takes one more word
// and then s_axis_tready drops until the result is taken.

`default_nettype none

module line_substring_matcher
    import lsm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LINE_MAX    = LINE_MAX_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] line_selected, [32:1] line_number, [43:33] line_length,
    // [75:44] selected_count, [79:76] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,  // [0] line_present
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t        cfg;
    match_ctrl_t ctrl;
    logic        hit;
    logic        step;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    // input register
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    // configuration registers
    lsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sliding window compare
    lsm_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctrl  (ctrl),
        .hit   (hit)
    );

    // line tracking and result register
    lsm_line_ctrl #(
        .LINE_MAX (LINE_MAX)
    ) u_line (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid_reg),
        .in_byte       (in_byte_reg),
        .in_eoi        (in_eoi_reg),
        .cfg           (cfg),
        .hit           (hit),
        .step          (step),
        .ctrl          (ctrl),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* design/lsm_cfg_regs.sv */
`default_nettype none

module lsm_cfg_regs
    import lsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    logic [3:0][CFG_DATA_W-1:0] pat_words_reg;
    logic [PLEN_W-1:0]          plen_reg;
    logic                       fold_reg;
    logic                       invert_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_words_reg <= '0;
            plen_reg      <= '0;
            fold_reg      <= 1'b0;
            invert_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAT_LO:     pat_words_reg[0] <= cfg_wdata;
                REG_PAT_MID_LO: pat_words_reg[1] <= cfg_wdata;
                REG_PAT_MID_HI: pat_words_reg[2] <= cfg_wdata;
                REG_PAT_HI:     pat_words_reg[3] <= cfg_wdata;
                REG_PAT_LEN:    plen_reg         <= cfg_wdata[PLEN_W-1:0];
                REG_FOLD_CASE:  fold_reg         <= cfg_wdata[0];
                REG_INVERT:     invert_reg       <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // the four words laid end to end give bytes 0 to 31
    assign cfg.pattern = pat_words_reg;
    assign cfg.plen    = plen_reg;
    assign cfg.fold    = fold_reg;
    assign cfg.invert  = invert_reg;

endmodule

`default_nettype wire

/* design/lsm_matcher.sv */
`default_nettype none

module lsm_matcher
    import lsm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire match_ctrl_t ctrl,
    output logic       hit
);

    localparam int SW = $clog2(PATTERN_MAX + 1);
    localparam logic [SW-1:0] SRCH_TOP = SW'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0][7:0] win_reg;
    logic [SW-1:0]               srch_reg;
    logic [SW-1:0]               srch_inc;
    logic [PATTERN_MAX-1:0][7:0] cand;
    logic [PATTERN_MAX-1:0]      eq;
    logic [PLEN_W-1:0]           plen_c;
    logic                        enough;

    // effective pattern length and searchable byte count after this byte
    always_comb
    begin
        plen_c   = (cfg.plen > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : cfg.plen;
        srch_inc = (srch_reg == SRCH_TOP) ? srch_reg : srch_reg + SW'(1);
        enough   = (PLEN_W'(srch_inc) >= plen_c);
    end

    // window with the new byte at position 0
    always_comb
    begin
        cand[0] = ctrl.data;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            cand[j] = win_reg[j-1];
        end
    end

    // position j lines up with pattern byte plen-1-j
    always_comb
    begin
        logic [PLEN_W-1:0] idx;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            idx = plen_c - PLEN_W'(j) - PLEN_W'(1);
            if (PLEN_W'(j) < plen_c)
            begin
                eq[j] = (fold_byte(cand[j], cfg.fold) ==
                         fold_byte(cfg.pattern[idx[PLEN_W-2:0]], cfg.fold));
            end
            else
            begin
                eq[j] = 1'b1;
            end
        end
        hit = enough && (&eq);
    end

    // searchable count, cleared at each line end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            srch_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            srch_reg <= srch_inc;
        end
    end

    // shift line of recent searchable bytes
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            win_reg <= cand;
        end
    end

endmodule

`default_nettype wire

/* design/lsm_line_ctrl.sv */
`default_nettype none

module lsm_line_ctrl
    import lsm_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    in_eoi,
    input  wire cfg_t                    cfg,
    input  wire logic                    hit,
    output logic                         step,
    output match_ctrl_t                  ctrl,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser
);

    localparam int LW = $clog2(LINE_MAX);
    localparam logic [LW-1:0] LINE_LAST = LW'(LINE_MAX - 1);

    logic [LW-1:0]    blen_reg,   blen_next;
    logic             nul_reg,    nul_next;
    logic             found_reg,  found_next;
    logic [CNT_W-1:0] lnum_reg,   lnum_next;
    logic [CNT_W-1:0] selcnt_reg, selcnt_next;

    logic                 out_valid_reg;
    logic                 o_present_reg, o_present_next;
    logic                 o_sel_reg,     o_sel_next;
    logic [CNT_W-1:0]     o_lnum_reg,    o_lnum_next;
    logic [LEN_OUT_W-1:0] o_len_reg,     o_len_next;
    logic [CNT_W-1:0]     o_selcnt_reg,  o_selcnt_next;
    logic                 o_final_reg,   o_final_next;

    logic close_line;
    logic emit;
    logic take;
    logic searchable;
    logic sel;

    // the stage moves when the result register is free or being drained
    assign step = in_valid && (!out_valid_reg || m_axis_tready);

    // decode the word in the input register
    always_comb
    begin
        if (in_eoi)
        begin
            close_line = (blen_reg != '0);
        end
        else
        begin
            close_line = (in_byte == CHAR_NL) || (blen_reg == LINE_LAST);
        end
        emit       = in_eoi || close_line;
        take       = !in_eoi && !close_line;
        searchable = take && !nul_reg && (in_byte != CHAR_NUL);
        sel        = found_reg ^ cfg.invert;
    end

    // window control
    always_comb
    begin
        ctrl.shift = step && searchable;
        ctrl.clear = step && close_line;
        ctrl.data  = in_byte;
    end

    // line state and counters
    always_comb
    begin
        blen_next   = blen_reg;
        nul_next    = nul_reg;
        found_next  = found_reg;
        lnum_next   = lnum_reg;
        selcnt_next = selcnt_reg;
        if (close_line)
        begin
            blen_next  = '0;
            nul_next   = 1'b0;
            found_next = 1'b0;
            if (lnum_reg != CNT_TOP)
            begin
                lnum_next = lnum_reg + CNT_W'(1);
            end
            if (sel && (selcnt_reg != CNT_TOP))
            begin
                selcnt_next = selcnt_reg + CNT_W'(1);
            end
        end
        else if (take)
        begin
            blen_next = blen_reg + LW'(1);
            if (!searchable)
            begin
                nul_next = 1'b1;
            end
            else if (hit)
            begin
                found_next = 1'b1;
            end
        end
    end

    // result fields, a bare end report when no line is open
    always_comb
    begin
        o_final_next  = in_eoi;
        o_selcnt_next = selcnt_next;
        if (close_line)
        begin
            o_present_next = 1'b1;
            o_sel_next     = sel;
            o_lnum_next    = lnum_reg;
            o_len_next     = LEN_OUT_W'(blen_reg);
        end
        else
        begin
            o_present_next = 1'b0;
            o_sel_next     = 1'b0;
            o_lnum_next    = '0;
            o_len_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg   <= '0;
            nul_reg    <= 1'b0;
            found_reg  <= 1'b0;
            lnum_reg   <= CNT_W'(1);
            selcnt_reg <= '0;
        end
        else if (step)
        begin
            blen_reg   <= blen_next;
            nul_reg    <= nul_next;
            found_reg  <= found_next;
            lnum_reg   <= lnum_next;
            selcnt_reg <= selcnt_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            o_present_reg <= o_present_next;
            o_sel_reg     <= o_sel_next;
            o_lnum_reg    <= o_lnum_next;
            o_len_reg     <= o_len_next;
            o_selcnt_reg  <= o_selcnt_next;
            o_final_reg   <= o_final_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, o_selcnt_reg, o_len_reg, o_lnum_reg, o_sel_reg};
    assign m_axis_tlast  = o_final_reg;
    assign m_axis_tuser  = o_present_reg;

endmodule

`default_nettype wire
